>>> hdl/scan_point_angular_rotation_defines.svh
`ifndef SCAN_POINT_ANGULAR_ROTATION_DEFINES_SVH
`define SCAN_POINT_ANGULAR_ROTATION_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPAR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPAR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/spar_pkg.sv
package spar_pkg;

    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 26;
    localparam int ZS_W       = 33;
    localparam int SUM_W      = 48;
    localparam int DRIFT_W    = 16;
    localparam int TRIG_W     = 16;
    localparam int CORDIC_W   = 18;
    localparam int MAG_W      = 49;
    localparam int FRAC_W     = 16;
    localparam int IP_W       = MAG_W - FRAC_W;
    localparam int DIGIT_BITS = 8;
    localparam int MOD_DIGITS = (IP_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int IP_PAD_W   = MOD_DIGITS * DIGIT_BITS;
    localparam int REM_W      = 9;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_W     = 22;
    localparam int ITER_IDX_W = 5;
    localparam int PROD_W     = ZS_W + TRIG_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [REM_W-1:0] DEG_WHOLE = 9'd360;

    localparam logic signed [ANGLE_W-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ANGLE_W-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ANGLE_W-1:0] DEG360 = 26'sd23592960;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 18'sd19899;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 2'd3;

    typedef struct packed {
        logic                  load;
        logic                  mod_step;
        logic                  load2;
        logic                  cordic_init;
        logic                  cordic_step;
        logic                  fix;
        logic                  mul_y;
        logic                  mul_z;
        logic                  finish;
        logic [ITER_IDX_W-1:0] iter;
    } spar_cmd_t;

    // arctangent of 2^-i in q16.16 degrees
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ITER_IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/spar_ctrl.sv
module spar_ctrl #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output spar_pkg::spar_cmd_t cmd
);
    import spar_pkg::*;

    localparam int ITER_EFF = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    localparam int CNT_MAX  = (ITER_EFF > MOD_DIGITS) ? ITER_EFF : MOD_DIGITS;
    localparam int CNT_W    = $clog2(CNT_MAX);

    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ITER_EFF - 1);
    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(MOD_DIGITS - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD1   = 4'd1;
    localparam logic [3:0] S_LOAD2  = 4'd2;
    localparam logic [3:0] S_MOD2   = 4'd3;
    localparam logic [3:0] S_CINIT  = 4'd4;
    localparam logic [3:0] S_CORDIC = 4'd5;
    localparam logic [3:0] S_FIX    = 4'd6;
    localparam logic [3:0] S_MULY   = 4'd7;
    localparam logic [3:0] S_MULZ   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.iter       = ITER_IDX_W'(cnt_reg);
        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MOD1;
                end
            end
            S_MOD1:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == MOD_LAST)
                begin
                    state_next = S_LOAD2;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_LOAD2:
            begin
                cmd.load2  = 1'b1;
                cnt_next   = '0;
                state_next = S_MOD2;
            end
            S_MOD2:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == MOD_LAST)
                begin
                    state_next = S_CINIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_MULZ;
            end
            S_MULZ:
            begin
                cmd.mul_z  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

endmodule

>>> hdl/spar_datapath.sv
module spar_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  spar_pkg::spar_cmd_t                    cmd,
    input  logic                                   cfg_we,
    input  logic        [spar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [spar_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [spar_pkg::COORD_W-1:0]    point_x,
    input  logic signed [spar_pkg::COORD_W-1:0]    point_z,
    input  logic                                   last_point,
    output logic signed [spar_pkg::COORD_W-1:0]    out_x,
    output logic signed [spar_pkg::COORD_W-1:0]    out_y,
    output logic signed [spar_pkg::COORD_W-1:0]    out_z,
    output logic                                   out_last
);
    import spar_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] OUT_MAX =
        {{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] OUT_MIN =
        {{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    localparam logic signed [CORDIC_W-1:0] TRIG_MAX =
        {{(CORDIC_W-TRIG_W+1){1'b0}}, {(TRIG_W-1){1'b1}}};
    localparam logic signed [CORDIC_W-1:0] TRIG_MIN =
        {{(CORDIC_W-TRIG_W+1){1'b1}}, {(TRIG_W-1){1'b0}}};
    localparam logic [DRIFT_W-1:0] DRIFT_MAX = {DRIFT_W{1'b1}};

    // configuration and scan state
    logic signed [COORD_W-1:0] offset_reg;
    logic signed [ANGLE_W-1:0] start_reg;
    logic signed [ANGLE_W-1:0] step_reg;
    logic                      wrap_reg;
    logic signed [SUM_W-1:0]   step_sum_reg, step_sum_next;
    logic        [DRIFT_W-1:0] drift_reg, drift_next;

    // working registers
    logic signed [COORD_W-1:0]  x_reg;
    logic signed [ZS_W-1:0]     zs_reg;
    logic                       last_reg;
    logic                       sign_reg;
    logic        [FRAC_W-1:0]   frac_reg;
    logic        [IP_PAD_W-1:0] ip_reg;
    logic        [REM_W-1:0]    rem_reg;
    logic                       hit_reg;
    logic signed [CORDIC_W-1:0] xc_reg;
    logic signed [CORDIC_W-1:0] yc_reg;
    logic signed [ANGLE_W-1:0]  t_reg;
    logic                       neg_reg;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W:0]     nsin_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [COORD_W-1:0]  ysat_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic signed [COORD_W-1:0]  out_z_reg;
    logic                       out_last_reg;

    logic signed [MAG_W-1:0]    angle_sum;
    logic        [MAG_W-1:0]    angle_mag;
    logic        [REM_W:0]      r_acc;
    logic signed [ANGLE_W-1:0]  mod_val;
    logic signed [MAG_W-1:0]    angle_eff;
    logic signed [MAG_W:0]      v_val;
    logic        [MAG_W-1:0]    v_mag;
    logic signed [ANGLE_W-1:0]  r_half;
    logic signed [ANGLE_W-1:0]  r_fold;
    logic                       r_neg;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [ANGLE_W-1:0]  atan_v;
    logic signed [CORDIC_W-1:0] xf;
    logic signed [CORDIC_W-1:0] yf;
    logic signed [TRIG_W-1:0]   sin_c;
    logic signed [TRIG_W:0]     mul_op;
    logic signed [PROD_W-1:0]   mul_res;
    logic signed [COORD_W-1:0]  prod_sat;
    logic signed [SUM_W:0]      sum_wide;

    function automatic logic signed [TRIG_W-1:0] clamp_trig(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [TRIG_W-1:0] r;
        if (v > TRIG_MAX)
        begin
            r = TRIG_W'(TRIG_MAX);
        end
        else if (v < TRIG_MIN)
        begin
            r = TRIG_W'(TRIG_MIN);
        end
        else
        begin
            r = TRIG_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0]  q;
        logic signed [COORD_W-1:0] r;
        q = (p + ROUND_HALF) >>> 15;
        if (q > OUT_MAX)
        begin
            r = COORD_W'(OUT_MAX);
        end
        else if (q < OUT_MIN)
        begin
            r = COORD_W'(OUT_MIN);
        end
        else
        begin
            r = COORD_W'(q);
        end
        return r;
    endfunction

    // angle formation and modulo-360 digit recurrence
    always_comb
    begin
        angle_sum = MAG_W'(start_reg) + MAG_W'(step_sum_reg);
        angle_mag = angle_sum[MAG_W-1] ? MAG_W'(-angle_sum) : MAG_W'(angle_sum);

        r_acc = {1'b0, rem_reg};
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            r_acc = {r_acc[REM_W-1:0], ip_reg[IP_PAD_W-1-k]};
            if (r_acc >= {1'b0, DEG_WHOLE})
            begin
                r_acc = r_acc - {1'b0, DEG_WHOLE};
            end
        end

        mod_val = sign_reg ? -$signed({1'b0, rem_reg, frac_reg})
                           :  $signed({1'b0, rem_reg, frac_reg});

        angle_eff = wrap_reg ? MAG_W'(mod_val) : angle_sum;
        v_val     = (MAG_W+1)'(angle_eff)
                    - (MAG_W+1)'($signed({1'b0, drift_reg, 14'b0}));
        v_mag     = v_val[MAG_W] ? MAG_W'(-v_val) : MAG_W'(v_val);
    end

    // range reduction, cordic micro-rotation, sign fix
    always_comb
    begin
        if (mod_val >= DEG180)
        begin
            r_half = mod_val - DEG360;
        end
        else if (mod_val < -DEG180)
        begin
            r_half = mod_val + DEG360;
        end
        else
        begin
            r_half = mod_val;
        end

        if (r_half > DEG90)
        begin
            r_fold = r_half - DEG180;
            r_neg  = 1'b1;
        end
        else if (r_half < -DEG90)
        begin
            r_fold = r_half + DEG180;
            r_neg  = 1'b1;
        end
        else
        begin
            r_fold = r_half;
            r_neg  = 1'b0;
        end

        dx     = yc_reg >>> cmd.iter;
        dy     = xc_reg >>> cmd.iter;
        atan_v = $signed(ANGLE_W'(atan_deg(cmd.iter)));

        xf    = neg_reg ? -xc_reg : xc_reg;
        yf    = neg_reg ? -yc_reg : yc_reg;
        sin_c = clamp_trig(yf);

        mul_op   = cmd.mul_y ? nsin_reg : (TRIG_W+1)'(cos_reg);
        mul_res  = zs_reg * mul_op;
        prod_sat = round_sat(prod_reg);
    end

    // scan state update at result write
    always_comb
    begin
        sum_wide      = (SUM_W+1)'(step_sum_reg) + (SUM_W+1)'(step_reg);
        step_sum_next = step_sum_reg;
        drift_next    = drift_reg;
        if (hit_reg && drift_reg != DRIFT_MAX)
        begin
            drift_next = drift_reg + DRIFT_W'(1);
        end
        if (last_reg)
        begin
            step_sum_next = '0;
            drift_next    = '0;
        end
        else if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            step_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            step_sum_next = SUM_W'(sum_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            start_reg    <= '0;
            step_reg     <= '0;
            wrap_reg     <= 1'b0;
            step_sum_reg <= '0;
            drift_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OFFSET: offset_reg <= COORD_W'(cfg_data);
                    REG_START:  start_reg  <= ANGLE_W'(cfg_data);
                    REG_STEP:   step_reg   <= ANGLE_W'(cfg_data);
                    REG_WRAP:   wrap_reg   <= cfg_data[0];
                endcase
            end
            if (cmd.finish)
            begin
                step_sum_reg <= step_sum_next;
                drift_reg    <= drift_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= point_x;
            zs_reg   <= ZS_W'(point_z) + ZS_W'(offset_reg);
            last_reg <= last_point;
            sign_reg <= angle_sum[MAG_W-1];
            frac_reg <= angle_mag[FRAC_W-1:0];
            ip_reg   <= IP_PAD_W'(angle_mag[MAG_W-1:FRAC_W]);
            rem_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            ip_reg  <= ip_reg << DIGIT_BITS;
            rem_reg <= r_acc[REM_W-1:0];
        end
        if (cmd.load2)
        begin
            hit_reg  <= (rem_reg == '0);
            sign_reg <= v_val[MAG_W];
            frac_reg <= v_mag[FRAC_W-1:0];
            ip_reg   <= IP_PAD_W'(v_mag[MAG_W-1:FRAC_W]);
            rem_reg  <= '0;
        end
        if (cmd.cordic_init)
        begin
            xc_reg  <= CORDIC_START;
            yc_reg  <= '0;
            t_reg   <= r_fold;
            neg_reg <= r_neg;
        end
        if (cmd.cordic_step)
        begin
            if (!t_reg[ANGLE_W-1])
            begin
                xc_reg <= xc_reg - dx;
                yc_reg <= yc_reg + dy;
                t_reg  <= t_reg - atan_v;
            end
            else
            begin
                xc_reg <= xc_reg + dx;
                yc_reg <= yc_reg - dy;
                t_reg  <= t_reg + atan_v;
            end
        end
        if (cmd.fix)
        begin
            cos_reg  <= clamp_trig(xf);
            nsin_reg <= -((TRIG_W+1)'(sin_c));
        end
        if (cmd.mul_y || cmd.mul_z)
        begin
            prod_reg <= mul_res;
        end
        if (cmd.mul_z)
        begin
            ysat_reg <= prod_sat;
        end
        if (cmd.finish)
        begin
            out_x_reg    <= x_reg;
            out_y_reg    <= ysat_reg;
            out_z_reg    <= prod_sat;
            out_last_reg <= last_reg;
        end
    end

    assign out_x    = out_x_reg;
    assign out_y    = out_y_reg;
    assign out_z    = out_z_reg;
    assign out_last = out_last_reg;

endmodule

>>> hdl/scan_point_angular_rotation.sv
// one point at a time: s_axis_tready is low from an input transaction until its result
//   is written, through two modulo-360 digit passes and the shared cordic iteration loop
// a finished point waits in the output register while the next point is taken
// reset: asynchronous, clears control state, configuration, step sum and drift; no clearing pass
module scan_point_angular_rotation #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,   // point_x, point_z
    input  logic                              s_axis_tlast,   // last_point
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [95:0]                       m_axis_tdata,   // out_x, out_y, out_z
    output logic                              m_axis_tlast,   // out_last
    input  logic                              cfg_we,
    input  logic [spar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spar_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spar_pkg::*;

    spar_cmd_t                 cmd;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;

    spar_ctrl #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    spar_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .point_x    ($signed(s_axis_tdata[31:0])),
        .point_z    ($signed(s_axis_tdata[63:32])),
        .last_point (s_axis_tlast),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_z, out_y, out_x};

endmodule

>>> hdl/spar_checker.sv
`include "scan_point_angular_rotation_defines.svh"

module spar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `SPAR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result changed or dropped")

    `SPAR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input ready right after a transaction")

    `SPAR_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready),
        "result appeared while no point was in progress")

    `SPAR_ASSERT_NEXT(a_no_quick_result,
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid,
        "result appeared one cycle after a transaction")

endmodule

bind scan_point_angular_rotation spar_checker u_spar_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    import spar_pkg::REG_OFFSET;
    import spar_pkg::REG_START;
    import spar_pkg::REG_STEP;
    import spar_pkg::REG_WRAP;

    localparam int CORDIC_STEPS = 16;
    localparam int TURN = 23592960;
    localparam int DRILL_ROWS = 38;

    localparam longint Q_ONE = 64'sd65536;
    localparam longint TURN_Q = longint'(spar_pkg::DEG360);
    localparam longint HALF_Q = longint'(spar_pkg::DEG180);
    localparam longint QUARTER_Q = longint'(spar_pkg::DEG90);
    localparam longint CORDIC_SEED = longint'(spar_pkg::CORDIC_START);
    localparam longint I32_MAX = (64'sd1 <<< 31) - 64'sd1;
    localparam longint I32_MIN = -(64'sd1 <<< 31);
    localparam longint SUM_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam longint SUM_MIN = -(64'sd1 <<< 47);

    // arctangent of 2^-i, q16.16 degrees
    localparam longint ARCTAN_Q [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } rot_point_t;

    typedef enum bit {ROW_REG, ROW_POINT} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [31:0] data;
        logic [31:0] x;
        logic [31:0] z;
        logic        last;
        bit          fix_y;
        logic [31:0] want_y;
        bit          fix_z;
        logic [31:0] want_z;
    } drill_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [spar_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [spar_pkg::CFG_DATA_W-1:0] cfg_data;

    // register copies and scan state
    longint      offset_q;
    longint      start_q;
    longint      step_q;
    bit          wrap_en;
    longint      angle_sum;
    int unsigned drift_count;

    rot_point_t  expected_points [$];
    int unsigned mismatch_count = 0;
    int unsigned src_idle_pct = 6;
    int unsigned sink_idle_pct = 59;
    rot_point_t  seen;
    rot_point_t  want;

    drill_row_t drill [DRILL_ROWS] = '{
        // after reset: zero z gives zero y and z, then z at its extremes
        '{ROW_POINT, '0, '0, 32'h00000000, 32'h00000000, 1'b0, 1'b1, '0, 1'b1, '0},
        '{ROW_POINT, '0, '0, 32'h7fffffff, 32'h00000000, 1'b0, 1'b1, '0, 1'b1, '0},
        '{ROW_POINT, '0, '0, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'hffffffff, 32'h80000000, 1'b1, 1'b0, '0, 1'b0, '0},
        // offset extremes saturate z at angle zero
        '{ROW_REG, REG_OFFSET, 32'h7fffffff, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h12345678, 32'h7fffffff, 1'b1, 1'b0, '0, 1'b1, 32'h7fffffff},
        '{ROW_REG, REG_OFFSET, 32'h80000000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h89abcdef, 32'h80000000, 1'b1, 1'b0, '0, 1'b1, 32'h80000000},
        // start +360, step -360: every point a multiple of 360
        '{ROW_REG, REG_OFFSET, 32'h00000000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_START, 32'h01680000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_STEP, 32'hfe980000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000000, 32'h00010000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000001, 32'hfff00000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000002, 32'h00010000, 1'b1, 1'b0, '0, 1'b0, '0},
        // wrap with negative angle: sign and fraction kept
        '{ROW_REG, REG_WRAP, 32'h00000001, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_START, 32'hfe984000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_STEP, 32'hffff0000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000005, 32'h00030000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000006, 32'h7fffffff, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000007, 32'h80000000, 1'b1, 1'b0, '0, 1'b0, '0},
        // quarter turns through both folds
        '{ROW_REG, REG_WRAP, 32'h00000000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_START, 32'h00000000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_STEP, 32'h005a0000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000010, 32'h00020000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000011, 32'hfffe0000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000012, 32'h00020000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000013, 32'h00028000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000014, 32'h00020000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000015, 32'h00020000, 1'b1, 1'b0, '0, 1'b0, '0},
        // start -360, step +360
        '{ROW_REG, REG_START, 32'hfe980000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_STEP, 32'h01680000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000020, 32'h00100000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000021, 32'h00100000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000022, 32'h00100000, 1'b1, 1'b0, '0, 1'b0, '0},
        // -0.5 degree truncates to integer zero
        '{ROW_REG, REG_START, 32'hffff8000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_REG, REG_STEP, 32'h00000000, '0, '0, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000030, 32'h01000000, 1'b0, 1'b0, '0, 1'b0, '0},
        '{ROW_POINT, '0, '0, 32'h00000031, 32'h01000000, 1'b1, 1'b0, '0, 1'b0, '0}
    };

    scan_point_angular_rotation #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // q16.16 times q1.15, round half up, saturate to 32 bits
    function automatic longint round_scale(longint zs, longint f);
        return sat((zs * f + 64'sd16384) >>> 15, I32_MIN, I32_MAX);
    endfunction

    function automatic rot_point_t rotate_point(logic [31:0] px, logic [31:0] pz,
                                                logic plast);
        longint     zs;
        longint     ang;
        longint     whole;
        longint     r;
        longint     cx;
        longint     cy;
        longint     dx;
        longint     dy;
        longint     t;
        longint     c;
        longint     s;
        bit         flip;
        rot_point_t res;
        zs = longint'($signed(pz)) + offset_q;
        ang = start_q + angle_sum;
        whole = ang / Q_ONE;
        if (wrap_en)
            ang = (whole % 360) * Q_ONE + (ang - whole * Q_ONE);
        r = (ang - longint'(drift_count) * 64'sd16384) % TURN_Q;
        if (r >= HALF_Q)
            r -= TURN_Q;
        else if (r < -HALF_Q)
            r += TURN_Q;
        flip = 1'b0;
        if (r > QUARTER_Q)
        begin
            r -= HALF_Q;
            flip = 1'b1;
        end
        else if (r < -QUARTER_Q)
        begin
            r += HALF_Q;
            flip = 1'b1;
        end
        cx = CORDIC_SEED;
        cy = 0;
        t = r;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (t >= 0)
            begin
                cx -= dx;
                cy += dy;
                t -= ARCTAN_Q[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                t += ARCTAN_Q[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        c = sat(cx, -64'sd32768, 64'sd32767);
        s = sat(cy, -64'sd32768, 64'sd32767);
        res.x = px;
        res.y = 32'(round_scale(zs, -s));
        res.z = 32'(round_scale(zs, c));
        res.last = plast;
        if ((ang / Q_ONE) % 360 == 0 && drift_count < 65535)
            drift_count++;
        if (plast)
        begin
            angle_sum = 0;
            drift_count = 0;
        end
        else
            angle_sum = sat(angle_sum + step_q, SUM_MIN, SUM_MAX);
        return res;
    endfunction

    function automatic logic [31:0] pick_reg_word(logic [1:0] idx);
        int          ang;
        int          n;
        logic [31:0] w;
        n = int'($urandom_range(1, 12));
        case ($urandom_range(0, 5))
            0: ang = 0;
            1: ang = (int'($urandom_range(0, 2)) - 1) * TURN;
            2: ang = int'($urandom_range(0, 2 * TURN)) - TURN;
            3: ang = ($urandom_range(0, 1) != 0) ? TURN / n : -(TURN / n);
            4: ang = int'($urandom_range(0, 2 * 65536)) - 65536;
            default: ang = ($urandom_range(0, 1) != 0) ? TURN : -TURN;
        endcase
        case (idx)
            REG_OFFSET:
                case ($urandom_range(0, 3))
                    0: w = '0;
                    1: w = $urandom;
                    2: w = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
                    default: w = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
                endcase
            REG_WRAP: w = $urandom;
            // bits above the angle width are don't care
            default: w = {6'($urandom), 26'(ang)};
        endcase
        return w;
    endfunction

    task automatic write_reg(logic [spar_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_OFFSET: offset_q = longint'($signed(data));
            REG_START:  start_q = longint'($signed(data[25:0]));
            REG_STEP:   step_q = longint'($signed(data[25:0]));
            REG_WRAP:   wrap_en = data[0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] pz, logic plast,
                              bit fix_y = 1'b0, logic [31:0] want_y = '0,
                              bit fix_z = 1'b0, logic [31:0] want_z = '0);
        rot_point_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pz, px};
        s_axis_tlast <= plast;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = rotate_point(px, pz, plast);
        if (fix_y)
            pred.y = want_y;
        if (fix_z)
            pred.z = want_z;
        expected_points.push_back(pred);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("scan_point_angular_rotation: mismatch");
        $finish;
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                    m_axis_tlast};
            if (expected_points.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: x %h y %h z %h last %b",
                             seen.x, seen.y, seen.z, seen.last);
            end
            else
            begin
                want = expected_points.pop_front();
                if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z ||
                    seen.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("point error: exp x %h y %h z %h last %b, got x %h y %h z %h last %b",
                                 want.x, want.y, want.z, want.last,
                                 seen.x, seen.y, seen.z, seen.last);
                end
            end
        end
    end

    initial
    begin
        int          sent;
        int          run_len;
        bit          drop_last;
        logic        mark;
        logic [31:0] pz;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        offset_q = 0;
        start_q = 0;
        step_q = 0;
        wrap_en = 1'b0;
        angle_sum = 0;
        drift_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < DRILL_ROWS; n++)
        begin
            if (drill[n].kind == ROW_REG)
                write_reg(drill[n].idx, drill[n].data);
            else
                send_point(drill[n].x, drill[n].z, drill[n].last,
                           drill[n].fix_y, drill[n].want_y,
                           drill[n].fix_z, drill[n].want_z);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 6 : ((ph == 1) ? 59 : 0);
            sink_idle_pct = (ph == 0) ? 59 : ((ph == 1) ? 6 : 0);
            for (int sp = 0; sp < 5; sp++)
            begin
                write_reg(REG_OFFSET, pick_reg_word(REG_OFFSET));
                write_reg(REG_START, pick_reg_word(REG_START));
                write_reg(REG_STEP, pick_reg_word(REG_STEP));
                write_reg(REG_WRAP, pick_reg_word(REG_WRAP));
                sent = 0;
                while (sent < 100)
                begin
                    run_len = int'($urandom_range(1, 40));
                    drop_last = ($urandom_range(0, 9) == 0);
                    for (int k = 0; k < run_len; k++)
                    begin
                        mark = (k == run_len - 1) && !drop_last;
                        if ($urandom_range(0, 24) == 0)
                            mark = ~mark;
                        case ($urandom_range(0, 9))
                            0: pz = $urandom;
                            1: pz = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
                            2: pz = '0;
                            default: pz = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
                        endcase
                        send_point($urandom, pz, mark);
                        sent++;
                    end
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("scan_point_angular_rotation: match");
        else
            $display("scan_point_angular_rotation: mismatch");
        $finish;
    end

endmodule

>>> scan_point_angular_rotation.f
+incdir+hdl
hdl/spar_pkg.sv
hdl/spar_ctrl.sv
hdl/spar_datapath.sv
hdl/scan_point_angular_rotation.sv
hdl/spar_checker.sv
sim/tb.sv
